// ===== src/nklp_pkg.sv =====
`timescale 1ns / 1ps
package nklp_pkg;
   localparam int TABLE_SLOTS  = 512;
   localparam int MAX_ENTRIES  = 256;
   localparam int MAX_NAME_LEN = 32;
   localparam int SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int ENTRY_W = $clog2(MAX_ENTRIES);
   localparam int POS_W   = $clog2(MAX_NAME_LEN);
   localparam int LEN_W   = $clog2(MAX_NAME_LEN + 1);
   localparam int STORE_W = ENTRY_W + POS_W;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_TOO_LONG  = 3'd5;

   // Name accumulator status handed to the probe sequencer.
   typedef struct packed {
      logic [31:0]      hash;
      logic [LEN_W-1:0] count;
      logic             overlong;
   } name_stat_type;
endpackage

// ===== src/name_keyed_linear_probe_table_core.sv =====
`timescale 1ns / 1ps
// Name lookup table with linear probing. A name arrives one character per
// beat; a beat that is not last gives no result. On the last beat a sequencer
// walks the slot table from hash modulo slot count; at each occupied slot it
// compares the entry length and, on equal length, each character, with one
// shared byte comparator against the 8192-byte name store. After reset a
// clearing pass empties the slot-used memory, during which no beat is
// accepted. The result sits in an output register.
module name_keyed_linear_probe_table_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_name_char,
   input  logic       req_name_last,
   input  logic [7:0] req_entry_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_found_index
);
   localparam int SW = nklp_pkg::SLOT_W;
   localparam int EW = nklp_pkg::ENTRY_W;
   localparam int PW = nklp_pkg::POS_W;
   localparam int LW = nklp_pkg::LEN_W;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_SLOT  = 4'd2;  // slot memories being read
   localparam logic [3:0] S_ENTRY = 4'd3;  // entry length being read
   localparam logic [3:0] S_CHK   = 4'd4;  // length compare
   localparam logic [3:0] S_CMP   = 4'd5;  // byte compare loop
   localparam logic [3:0] S_NEXT  = 4'd6;
   localparam logic [3:0] S_WRITE = 4'd7;  // copy name into store
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]    state_ff, state_in;
   logic [SW-1:0] pos_ff, pos_in, start_ff, start_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic          mode_ff, mode_in;
   logic [EW-1:0] ent_ff, ent_in;
   logic [2:0]    st_ff, st_in;
   logic [7:0]    fi_ff, fi_in;
   logic          rv_ff, rv_in;

   logic take, clear_name;
   logic [7:0] char_low;
   logic nb_wr;
   logic [PW-1:0] nb_wpos;
   nklp_pkg::name_stat_type stat;

   logic          used_we, used_wd, used_rd;
   logic [SW-1:0] used_wa;
   logic          tab_we;
   logic [EW-1:0] tab_rd;
   logic          len_we;
   logic [LW-1:0] len_rd;
   logic          st_we;
   logic [7:0]    store_rd, buf_rd;
   logic [PW-1:0] buf_ra;
   logic [EW-1:0] cur_ent;

   assign req_stall = !(state_ff == S_IDLE) || rv_ff;
   assign take      = req_valid && !req_stall;
   // The name stays in the accumulator until the probe has finished with it.
   assign clear_name = (state_ff == S_DONE);

   nklp_name_acc u_acc (
      .clock, .reset, .take, .char_in(req_name_char), .clear(clear_name),
      .char_low, .wr_en(nb_wr), .wr_pos(nb_wpos), .stat
   );

   // Entry number under comparison comes from the slot during a probe.
   assign cur_ent = (state_ff == S_WRITE) ? ent_ff : tab_rd;
   assign buf_ra  = idx_ff[PW-1:0];

   nklp_ram #(.WIDTH(8), .DEPTH(nklp_pkg::MAX_NAME_LEN)) u_buf (
      .clock, .wr_en(nb_wr), .wr_addr(nb_wpos), .wr_data(char_low),
      .rd_addr(buf_ra), .rd_data(buf_rd));

   nklp_ram #(.WIDTH(1), .DEPTH(nklp_pkg::TABLE_SLOTS)) u_used (
      .clock, .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
      .rd_addr(pos_in), .rd_data(used_rd));

   nklp_ram #(.WIDTH(EW), .DEPTH(nklp_pkg::TABLE_SLOTS)) u_tab (
      .clock, .wr_en(tab_we), .wr_addr(pos_ff), .wr_data(ent_ff),
      .rd_addr(pos_in), .rd_data(tab_rd));

   nklp_ram #(.WIDTH(LW), .DEPTH(nklp_pkg::MAX_ENTRIES)) u_len (
      .clock, .wr_en(len_we), .wr_addr(ent_ff), .wr_data(stat.count),
      .rd_addr(tab_rd), .rd_data(len_rd));

   nklp_ram #(.WIDTH(8), .DEPTH(nklp_pkg::MAX_ENTRIES * nklp_pkg::MAX_NAME_LEN)) u_store (
      .clock, .wr_en(st_we), .wr_addr({ent_ff, idx_ff[PW-1:0] - PW'(1)}), .wr_data(buf_rd),
      .rd_addr({cur_ent, idx_ff[PW-1:0]}), .rd_data(store_rd));

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      idx_in   = idx_ff;
      mode_in  = mode_ff;
      ent_in   = ent_ff;
      st_in    = st_ff;
      fi_in    = fi_ff;
      rv_in    = rv_ff && rsp_stall;
      used_we  = 1'b0;
      used_wa  = pos_ff;
      used_wd  = 1'b1;
      tab_we   = 1'b0;
      len_we   = 1'b0;
      st_we    = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            used_we = 1'b1;
            used_wd = 1'b0;
            pos_in  = pos_ff + 1'b1;
            if (pos_ff == SW'(nklp_pkg::TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (take && req_name_last) begin
               mode_in = req_mode;
               ent_in  = req_entry_index[EW-1:0];
               fi_in   = 8'd0;
               // The last beat itself may still fit; recompute overflow here.
               if (stat.overlong || stat.count == LW'(nklp_pkg::MAX_NAME_LEN)) begin
                  st_in    = nklp_pkg::ST_TOO_LONG;
                  state_in = S_DONE;
               end else if (req_mode && 9'(req_entry_index) >= 9'(nklp_pkg::MAX_ENTRIES)) begin
                  st_in    = nklp_pkg::ST_FULL;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SLOT;
                  pos_in   = SW'((stat.hash ^ {24'd0, char_low}) * nklp_pkg::FNV_PRIME);
                  start_in = pos_in;
                  st_in    = req_mode ? nklp_pkg::ST_FULL : nklp_pkg::ST_NOT_FOUND;
               end
            end
         end
         S_SLOT: begin
            idx_in = '0;
            if (!used_rd) begin
               if (mode_ff) begin
                  used_we  = 1'b1;
                  tab_we   = 1'b1;
                  len_we   = 1'b1;
                  st_in    = nklp_pkg::ST_INSERTED;
                  state_in = S_WRITE;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_ENTRY;
            end
         end
         S_ENTRY: state_in = S_CHK;
         S_CHK: begin
            if (len_rd != stat.count) begin
               state_in = S_NEXT;
            end else if (stat.count == '0) begin
               state_in = S_CMP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // Store and buffer outputs hold the byte at idx_ff - 1.
            if (idx_ff != '0 && store_rd != buf_rd) begin
               state_in = S_NEXT;
               idx_in   = '0;
            end else if (idx_ff == stat.count) begin
               st_in    = mode_ff ? nklp_pkg::ST_DUPLICATE : nklp_pkg::ST_FOUND;
               fi_in    = mode_ff ? 8'd0 : 8'(tab_rd);
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_NEXT: begin
            pos_in = pos_ff + 1'b1;
            idx_in = '0;
            state_in = (pos_in == start_ff) ? S_DONE : S_SLOT;
         end
         S_WRITE: begin
            if (idx_ff != '0) begin
               st_we = 1'b1;
            end
            if (idx_ff == stat.count) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         pos_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         rv_ff    <= rv_in;
      end
      start_ff <= start_in;
      idx_ff   <= idx_in;
      mode_ff  <= mode_in;
      ent_ff   <= ent_in;
      st_ff    <= st_in;
      fi_ff    <= fi_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = st_ff;
   assign rsp_found_index = fi_ff;

`ifndef NO_ASSERTIONS
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !take)
      else $error("beat taken while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid)
      else $error("result not raised");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");
`endif
endmodule

// ===== src/nklp_ram.sv =====
`timescale 1ns / 1ps
module nklp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== src/nklp_name_acc.sv =====
`timescale 1ns / 1ps
// Lowercases taken chars, folds up to 32 of them into FNV-1a, one per cycle.
module nklp_name_acc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [7:0]                  char_in,
   input  logic                        clear,
   output logic [7:0]                  char_low,
   output logic                        wr_en,
   output logic [nklp_pkg::POS_W-1:0]  wr_pos,
   output nklp_pkg::name_stat_type     stat
);
   logic [31:0]                hash_ff, hash_in, mixed;
   logic [nklp_pkg::LEN_W-1:0] count_ff, count_in;
   logic                       over_ff, over_in;
   logic                       room;

   assign char_low = (char_in >= 8'h41 && char_in <= 8'h5A) ? char_in + 8'h20 : char_in;
   assign room     = count_ff < nklp_pkg::LEN_W'(nklp_pkg::MAX_NAME_LEN);
   assign wr_en    = take && room;
   assign wr_pos   = count_ff[nklp_pkg::POS_W-1:0];
   assign mixed    = hash_ff ^ {24'd0, char_low};

   always_comb begin
      hash_in  = hash_ff;
      count_in = count_ff;
      over_in  = over_ff;
      if (clear) begin
         hash_in  = nklp_pkg::FNV_BASIS;
         count_in = '0;
         over_in  = 1'b0;
      end else if (take) begin
         if (room) begin
            hash_in  = mixed * nklp_pkg::FNV_PRIME;
            count_in = count_ff + 1'b1;
         end else begin
            over_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= nklp_pkg::FNV_BASIS;
         count_ff <= '0;
         over_ff  <= 1'b0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
         over_ff  <= over_in;
      end
   end

   assign stat.hash     = hash_ff;
   assign stat.count    = count_ff;
   assign stat.overlong = over_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nklp_pkg::LEN_W'(nklp_pkg::MAX_NAME_LEN))
      else $error("name count beyond bound");
   a_over_full: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> count_ff == nklp_pkg::LEN_W'(nklp_pkg::MAX_NAME_LEN))
      else $error("overlong without full buffer");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      clear |=> count_ff == '0 && !over_ff)
      else $error("clear did not reset name");
`endif
endmodule
